@@ hw/rtl/cpss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpss_pkg: shared constants and types
// Widths, the queue depth and the back part sequencer state type.
// ----------------------------------------------------------------------------
package cpss_pkg;
   localparam int COORD_BITS_DEF  = 24;
   localparam int T_FRAC_BITS_DEF = 16;
   localparam int DIST_BITS       = 51;
   localparam int QUEUE_DEPTH     = 2;

   // Back part sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_DIV,
      ST_LERP,
      ST_DIST,
      ST_UPD
   } back_state_type;
endpackage
`default_nettype wire

@@ hw/rtl/cpss_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpss_front: request intake
// Queues the query, segment end points and run marks of each request.
// ----------------------------------------------------------------------------
module cpss_front #(
   parameter int COORD_BITS = cpss_pkg::COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_stall,
   input  wire logic signed [COORD_BITS-1:0] qx,
   input  wire logic signed [COORD_BITS-1:0] qy,
   input  wire logic signed [COORD_BITS-1:0] ax,
   input  wire logic signed [COORD_BITS-1:0] ay,
   input  wire logic signed [COORD_BITS-1:0] bx,
   input  wire logic signed [COORD_BITS-1:0] by,
   input  wire logic                         first_in,
   input  wire logic                         last_in,
   output logic                              q_valid,
   input  wire logic                         q_take,
   output logic [6*COORD_BITS+1:0]           q_data
);
   localparam int W = 6 * COORD_BITS + 2;
   localparam int D = cpss_pkg::QUEUE_DEPTH;

   logic [W-1:0] mem_ff [D];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;

   assign in_stall = (cnt_ff == 2'(D));
   assign push     = in_valid && !in_stall;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = mem_ff[rp_ff];

   // Pointer and fill count update.
   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = (q_take && q_valid) ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage: a, b, q and the run marks.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= {qx, qy, ax, ay, bx, by, first_in, last_in};
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/cpss_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpss_back: projection and selection
// Projects the query onto one segment with a serial divider, keeps the best.
// ----------------------------------------------------------------------------
module cpss_back #(
   parameter int COORD_BITS  = cpss_pkg::COORD_BITS_DEF,
   parameter int T_FRAC_BITS = cpss_pkg::T_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   output logic                                   q_take,
   input  wire logic [6*COORD_BITS+1:0]           q_data,
   output logic                                   out_valid,
   input  wire logic                              out_stall,
   output logic signed [COORD_BITS-1:0]           out_x,
   output logic signed [COORD_BITS-1:0]           out_y,
   output logic [cpss_pkg::DIST_BITS-1:0]         out_d
);
   localparam int C  = COORD_BITS;
   localparam int DW = C + 1;          // difference width
   localparam int PW = 2 * DW + 1;     // sum of two products
   localparam int TW = T_FRAC_BITS + 1;
   localparam int TC = $clog2(T_FRAC_BITS + 1);
   localparam int DB = cpss_pkg::DIST_BITS;

   cpss_pkg::back_state_type st_ff, st_in;
   logic signed [C-1:0]  qx_ff, qy_ff, ax_ff, ay_ff;
   logic signed [DW-1:0] abx_ff, aby_ff, apx_ff, apy_ff;
   logic                 first_ff, last_ff;
   logic signed [PW-1:0] ab2_ff, dot_ff, r_ff;
   logic [TW-1:0]        t_ff;
   logic [TC-1:0]        k_ff;
   logic signed [C-1:0]  cx_ff, cy_ff;
   logic [PW-1:0]        d2_ff;
   logic                 has_ff;
   logic [DB-1:0]        bd_ff;
   logic signed [C-1:0]  bx_ff, by_ff;
   logic                 ov_ff;

   logic signed [PW-1:0]   r2;
   logic signed [DW+TW:0]  mx, my;
   logic signed [DW:0]     ex, ey;
   logic [DB-1:0]          cand_d;
   logic                   take_it, keep;
   logic                   upd_go;

   // A finished run waits in its final step only while the previous response
   // is still stalled; other segments pass straight through.
   assign q_take    = (st_ff == cpss_pkg::ST_IDLE);
   assign upd_go    = (st_ff == cpss_pkg::ST_UPD) && !(last_ff && ov_ff && out_stall);
   assign out_valid = ov_ff;

   // Divider step, interpolation, distance terms and the best-point comparison.
   always_comb begin
      r2 = r_ff <<< 1;
      mx = (abx_ff * $signed({1'b0, t_ff})) >>> T_FRAC_BITS;
      my = (aby_ff * $signed({1'b0, t_ff})) >>> T_FRAC_BITS;
      // Arithmetic shift floors; fix negatives to round toward zero.
      if (abx_ff < 0 && ((abx_ff * $signed({1'b0, t_ff})) & ((1 << T_FRAC_BITS) - 1)) != 0)
         mx = mx + 1'b1;
      if (aby_ff < 0 && ((aby_ff * $signed({1'b0, t_ff})) & ((1 << T_FRAC_BITS) - 1)) != 0)
         my = my + 1'b1;
      ex = (DW+1)'(qx_ff) - (DW+1)'(cx_ff);
      ey = (DW+1)'(qy_ff) - (DW+1)'(cy_ff);
      cand_d = (d2_ff > PW'({DB{1'b1}})) ? {DB{1'b1}} : DB'(d2_ff);
      keep = first_ff ? 1'b0 : has_ff;
      take_it = !keep || (cand_d < bd_ff);
   end

   // Sequencer.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         cpss_pkg::ST_IDLE: if (q_valid && q_take) st_in = cpss_pkg::ST_MUL1;
         cpss_pkg::ST_MUL1: st_in = cpss_pkg::ST_DIV;
         cpss_pkg::ST_DIV:  if (ab2_ff == 0 || dot_ff <= 0 || dot_ff >= ab2_ff ||
                                k_ff == TC'(T_FRAC_BITS)) st_in = cpss_pkg::ST_LERP;
         cpss_pkg::ST_LERP: st_in = cpss_pkg::ST_DIST;
         cpss_pkg::ST_DIST: st_in = cpss_pkg::ST_UPD;
         cpss_pkg::ST_UPD:  if (upd_go) st_in = cpss_pkg::ST_IDLE;
         default:           st_in = cpss_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= cpss_pkg::ST_IDLE;
         has_ff <= 1'b0;
         ov_ff  <= 1'b0;
         bd_ff  <= '0;
         bx_ff  <= '0;
         by_ff  <= '0;
      end else begin
         st_ff <= st_in;
         if (upd_go && last_ff) ov_ff <= 1'b1;
         else if (ov_ff && !out_stall) ov_ff <= 1'b0;
         if (upd_go) begin
            has_ff <= last_ff ? 1'b0 : (keep || take_it);
            if (take_it) begin
               bd_ff <= cand_d;
               bx_ff <= cx_ff;
               by_ff <= cy_ff;
            end
            if (last_ff) begin
               out_x <= take_it ? cx_ff : bx_ff;
               out_y <= take_it ? cy_ff : by_ff;
               out_d <= take_it ? cand_d : bd_ff;
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (st_ff)
         cpss_pkg::ST_IDLE: begin
            if (q_valid && q_take) begin
               qx_ff    <= q_data[6*C+1 -: C];
               qy_ff    <= q_data[5*C+1 -: C];
               ax_ff    <= q_data[4*C+1 -: C];
               ay_ff    <= q_data[3*C+1 -: C];
               abx_ff   <= DW'($signed(q_data[2*C+1 -: C])) - DW'($signed(q_data[4*C+1 -: C]));
               aby_ff   <= DW'($signed(q_data[C+1 -: C])) - DW'($signed(q_data[3*C+1 -: C]));
               apx_ff   <= DW'($signed(q_data[6*C+1 -: C])) - DW'($signed(q_data[4*C+1 -: C]));
               apy_ff   <= DW'($signed(q_data[5*C+1 -: C])) - DW'($signed(q_data[3*C+1 -: C]));
               first_ff <= q_data[1];
               last_ff  <= q_data[0];
            end
         end
         cpss_pkg::ST_MUL1: begin
            ab2_ff <= PW'(abx_ff * abx_ff) + PW'(aby_ff * aby_ff);
            dot_ff <= PW'(abx_ff * apx_ff) + PW'(aby_ff * apy_ff);
            r_ff   <= PW'(abx_ff * apx_ff) + PW'(aby_ff * apy_ff);
            t_ff   <= '0;
            k_ff   <= '0;
         end
         cpss_pkg::ST_DIV: begin
            if (ab2_ff == 0 || dot_ff <= 0) begin
               t_ff <= '0;
            end else if (dot_ff >= ab2_ff) begin
               t_ff <= TW'(1) << T_FRAC_BITS;
            end else if (k_ff != TC'(T_FRAC_BITS)) begin
               k_ff <= k_ff + 1'b1;
               if (r2 >= ab2_ff) begin
                  r_ff <= r2 - ab2_ff;
                  t_ff <= {t_ff[TW-2:0], 1'b1};
               end else begin
                  r_ff <= r2;
                  t_ff <= {t_ff[TW-2:0], 1'b0};
               end
            end
         end
         cpss_pkg::ST_LERP: begin
            cx_ff <= C'(DW'(ax_ff) + DW'(mx));
            cy_ff <= C'(DW'(ay_ff) + DW'(my));
         end
         cpss_pkg::ST_DIST: begin
            d2_ff <= PW'(ex * ex) + PW'(ey * ey);
         end
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire

@@ hw/rtl/closest_point_on_segment_set.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// closest_point_on_segment_set: closest point on a set of segments
// Streams segments of a run and returns the nearest projected point.
// ----------------------------------------------------------------------------
// Each request carries the query and one segment; the request marked last
// yields one response with the closest point and its squared distance. A
// segment passes through the back part states MUL1, DIV, LERP, DIST and UPD;
// DIV steps the bit-serial divider when t has to be formed, and skips those
// steps when t clamps to zero or one or the segment is degenerate; a two-entry
// queue lets the next requests be accepted meanwhile. A finished run waits
// in the back part only while the previous response is still stalled.
module closest_point_on_segment_set #(
   parameter int COORD_BITS  = cpss_pkg::COORD_BITS_DEF,
   parameter int T_FRAC_BITS = cpss_pkg::T_FRAC_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [COORD_BITS-1:0]   req_query_x,
   input  wire logic signed [COORD_BITS-1:0]   req_query_y,
   input  wire logic signed [COORD_BITS-1:0]   req_seg_start_x,
   input  wire logic signed [COORD_BITS-1:0]   req_seg_start_y,
   input  wire logic signed [COORD_BITS-1:0]   req_seg_end_x,
   input  wire logic signed [COORD_BITS-1:0]   req_seg_end_y,
   input  wire logic                           req_first_segment,
   input  wire logic                           req_last_segment,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [COORD_BITS-1:0]        rsp_closest_x,
   output logic signed [COORD_BITS-1:0]        rsp_closest_y,
   output logic [cpss_pkg::DIST_BITS-1:0]      rsp_best_sq_dist
);
   logic                      q_valid, q_take;
   logic [6*COORD_BITS+1:0]   q_data;

   // Intake and queue.
   cpss_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall),
      .qx(req_query_x), .qy(req_query_y),
      .ax(req_seg_start_x), .ay(req_seg_start_y),
      .bx(req_seg_end_x), .by(req_seg_end_y),
      .first_in(req_first_segment), .last_in(req_last_segment),
      .q_valid, .q_take, .q_data
   );

   // Projection and selection.
   cpss_back #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_data,
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_x(rsp_closest_x), .out_y(rsp_closest_y), .out_d(rsp_best_sq_dist)
   );
endmodule
`default_nettype wire

@@ hw/rtl/cpss_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpss_checker: port checks
// Watches the ports of the top level over time.
// ----------------------------------------------------------------------------
module cpss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [50:0] rsp_best_sq_dist,
   input wire logic        req_stall
);
   // A stalled response stays valid and keeps its distance.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_best_sq_dist))
      else $error("response changed while stalled");

   // Nothing comes out straight after reset.
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   // The queue is empty after reset.
   a_rdy: assert property (@(posedge clock) $past(reset) |-> !req_stall)
      else $error("request stalled right after reset");

   // A valid response carries a known distance.
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_best_sq_dist))
      else $error("response distance unknown");
endmodule

bind closest_point_on_segment_set cpss_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_best_sq_dist, .req_stall
);
`default_nettype wire

@@ sim/tb_closest_point_on_segment_set.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_point_on_segment_set: self-checking bench for the segment set
// Streams runs of segments with random idling on both sides, predicts the
// nearest projected point of each run and checks every response in order.
// ----------------------------------------------------------------------------

// Holds the predicted nearest points of completed runs and checks responses.
class nearest_point_board;
   bit               run_open;
   logic [50:0]      run_dist;
   logic signed [23:0] run_x;
   logic signed [23:0] run_y;
   logic [23:0]      want_x[$];
   logic [23:0]      want_y[$];
   logic [50:0]      want_d[$];
   int               errors;
   int               checked;

   function void clear();
      run_open = 0;
      run_dist = '0;
      run_x = '0;
      run_y = '0;
      errors = 0;
      checked = 0;
   endfunction

   // Projects the query onto one segment and folds it into the current run.
   function void note_request(logic signed [23:0] qx, logic signed [23:0] qy,
                              logic signed [23:0] ax, logic signed [23:0] ay,
                              logic signed [23:0] bx, logic signed [23:0] by,
                              bit first, bit last);
      longint    abx, aby, apx, apy, cx, cy, dx, dy;
      logic [127:0] ab2, dot, d2;
      longint    t;
      logic [50:0] sq_dist;
      abx = longint'(bx) - longint'(ax);
      aby = longint'(by) - longint'(ay);
      apx = longint'(qx) - longint'(ax);
      apy = longint'(qy) - longint'(ay);
      cx = ax;
      cy = ay;
      ab2 = abx * abx + aby * aby;
      if (ab2 != 0) begin
         // The dot product fits comfortably in 64 signed bits at 24-bit input.
         t = 0;
         if (abx * apx + aby * apy > 0) begin
            dot = abx * apx + aby * apy;
            if (dot >= ab2) t = 1 << 16;
            else t = longint'((dot << 16) / ab2);
         end
         cx = (abx < 0) ? ax - (((-abx) * t) >>> 16) : ax + ((abx * t) >>> 16);
         cy = (aby < 0) ? ay - (((-aby) * t) >>> 16) : ay + ((aby * t) >>> 16);
      end
      dx = longint'(qx) - cx;
      dy = longint'(qy) - cy;
      d2 = dx * dx + dy * dy;
      sq_dist = (d2 > 128'h7_FFFF_FFFF_FFFF) ? 51'h7_FFFF_FFFF_FFFF : d2[50:0];
      if (first) run_open = 0;
      if (!run_open || sq_dist < run_dist) begin
         run_dist = sq_dist;
         run_x = cx[23:0];
         run_y = cy[23:0];
         run_open = 1;
      end
      if (last) begin
         want_x = {want_x, run_x};
         want_y = {want_y, run_y};
         want_d = {want_d, run_dist};
         run_open = 0;
      end
   endfunction

   function void check_response(logic [23:0] x, logic [23:0] y, logic [50:0] d);
      logic [23:0] ex, ey;
      logic [50:0] ed;
      if (want_x.size() == 0) begin
         $error("response with no run pending: x=%h y=%h dist=%h", x, y, d);
         errors++;
         return;
      end
      ex = want_x.pop_front();
      ey = want_y.pop_front();
      ed = want_d.pop_front();
      checked++;
      if (x !== ex) begin
         $error("closest_x expected %h actual %h", ex, x);
         errors++;
      end
      if (y !== ey) begin
         $error("closest_y expected %h actual %h", ey, y);
         errors++;
      end
      if (d !== ed) begin
         $error("best_sq_dist expected %h actual %h", ed, d);
         errors++;
      end
   endfunction

   function int pending();
      return want_x.size();
   endfunction
endclass

module tb_closest_point_on_segment_set;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [23:0] req_query_x, req_query_y;
   logic signed [23:0] req_seg_start_x, req_seg_start_y;
   logic signed [23:0] req_seg_end_x, req_seg_end_y;
   logic req_first_segment, req_last_segment;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [23:0] rsp_closest_x, rsp_closest_y;
   logic [50:0] rsp_best_sq_dist;

   nearest_point_board board;
   int  cycle_count = 0;
   bit  calm;        // no idling while set
   bit  hold_rsp;    // long receiver hold-off request
   int  sent;

   closest_point_on_segment_set DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_query_x(req_query_x), .req_query_y(req_query_y),
      .req_seg_start_x(req_seg_start_x), .req_seg_start_y(req_seg_start_y),
      .req_seg_end_x(req_seg_end_x), .req_seg_end_y(req_seg_end_y),
      .req_first_segment(req_first_segment), .req_last_segment(req_last_segment),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_closest_x(rsp_closest_x), .rsp_closest_y(rsp_closest_y),
      .rsp_best_sq_dist(rsp_best_sq_dist)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_closest_point_on_segment_set failed");
         $finish;
      end
   end

   // Note accepted requests and check accepted responses at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_request(req_query_x, req_query_y, req_seg_start_x, req_seg_start_y,
                            req_seg_end_x, req_seg_end_y, req_first_segment,
                            req_last_segment);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_closest_x, rsp_closest_y, rsp_best_sq_dist);
   end

   // Receiver: random stalls, with one long counted hold-off on request.
   initial begin
      int hold;
      bit held;
      rsp_stall = 1'b0;
      hold = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !held) begin
            hold = 400;
            held = 1;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (calm) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(99) < 29);
      end
   end

   function automatic logic signed [23:0] pick_coord(int style);
      case (style)
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return $signed(24'($urandom_range(8191)) - 24'sd4096);
         default: return $signed(24'($urandom));
      endcase
   endfunction

   // Drives one request and holds it until accepted.
   task automatic send_segment(logic signed [23:0] qx, logic signed [23:0] qy,
                               logic signed [23:0] ax, logic signed [23:0] ay,
                               logic signed [23:0] bx, logic signed [23:0] by,
                               bit first, bit last);
      int idle;
      idle = 0;
      while (!calm && $urandom_range(99) < 29) idle++;
      @(negedge clock);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_query_x <= qx;
      req_query_y <= qy;
      req_seg_start_x <= ax;
      req_seg_start_y <= ay;
      req_seg_end_x <= bx;
      req_seg_end_y <= by;
      req_first_segment <= first;
      req_last_segment <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // One run of random segments sharing a query point; the first mark is sometimes left off.
   task automatic send_run(int segs, int style);
      logic signed [23:0] qx, qy;
      bit mark_first;
      qx = pick_coord(style);
      qy = pick_coord(style);
      mark_first = ($urandom_range(9) != 0);
      for (int i = 0; i < segs; i++) begin
         logic signed [23:0] ax, ay, bx, by;
         ax = pick_coord($urandom_range(1) ? style : $urandom_range(3));
         ay = pick_coord(style);
         if ($urandom_range(15) == 0) begin
            bx = ax;
            by = ay;
         end else begin
            bx = pick_coord(style);
            by = pick_coord($urandom_range(3));
         end
         send_segment(qx, qy, ax, ay, bx, by, (i == 0) && mark_first, i == segs - 1);
      end
   endtask

   // Stops offering requests until every expected response has come.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   initial begin
      int wait_cycles;
      board = new();
      board.clear();
      calm = 0;
      hold_rsp = 0;
      sent = 0;
      req_valid = 1'b0;
      req_query_x = '0; req_query_y = '0;
      req_seg_start_x = '0; req_seg_start_y = '0;
      req_seg_end_x = '0; req_seg_end_y = '0;
      req_first_segment = 1'b0; req_last_segment = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, degenerate segment, clamping, ties, marks.
      send_segment(0, 0, 24'sh001000, 0, 24'sh001000, 0, 1, 1);
      send_segment(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
                   24'sh7FFFFF, 24'sh800000, 1, 1);
      send_segment(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
                   24'sh800000, 24'sh7FFFFF, 1, 1);
      send_segment(24'sh800000, 0, 0, 0, 24'sh001000, 0, 1, 0);
      send_segment(24'sh7FFFFF, 0, 0, 0, 24'sh001000, 0, 0, 1);
      send_segment(0, 24'sh000800, 24'shFFF000, 0, 24'sh001000, 0, 1, 0);
      send_segment(0, 24'shFFF800, 24'shFFF000, 0, 24'sh001000, 0, 0, 0);
      send_segment(24'sh000123, 24'sh000456, 24'sh000001, 24'sh000003,
                   24'sh000777, 24'sh000005, 0, 1);
      send_segment(0, 0, 24'sh000010, 24'sh000010, 24'sh000010, 24'sh000010, 0, 0);
      send_segment(24'sh000005, 0, 24'sh000010, 24'sh000010,
                   24'sh000010, 24'sh000010, 0, 1);
      send_segment(24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555,
                   24'sh123456, 24'shFEDCBA, 1, 1);
      drain();

      // Random runs, with a quiet stretch and a long receiver hold-off.
      while (sent < 1760) begin
         if (sent > 500 && sent < 700) calm = 1;
         else calm = 0;
         if (sent > 900) hold_rsp = 1;
         if ($urandom_range(29) == 0) begin
            // Noise: a random segment with random marks.
            send_segment(pick_coord(3), pick_coord(3), pick_coord(3), pick_coord(3),
                         pick_coord(3), pick_coord(3), $urandom_range(1),
                         $urandom_range(1));
         end else begin
            send_run($urandom_range(1, 6), $urandom_range(3));
         end
         if ($urandom_range(99) == 0) drain();
      end
      calm = 0;
      // Close any run left open so that it is checked too.
      send_segment(0, 0, 0, 0, 24'sh000100, 0, 0, 1);
      @(negedge clock);
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (board.pending() != 0 && wait_cycles < 20000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (50) @(negedge clock);
      $display("Sent %0d segments; checked %0d run results with random stalls.",
               sent, board.checked);
      if (board.errors == 0 && board.pending() == 0)
         $display("tb_closest_point_on_segment_set passed");
      else
         $display("tb_closest_point_on_segment_set failed");
      $finish;
   end
endmodule
